/* rtl/core/tdp_pkg.sv */
package tdp_pkg;

  typedef enum logic [1:0] {
    VERDICT_NOT_PRIME = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_NO_TEST   = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } tdp_state_e;

  // results for n below four are settled without a trial
  localparam int unsigned SmallLimit = 4;

endpackage

/* rtl/core/tdp_serial_div.sv */
module tdp_serial_div #(
  parameter int W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [W:0]   rem_sh;
  logic [W+1:0] diff;
  logic         fits;

  // one quotient bit per cycle, restoring form
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign fits   = !diff[W+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with empty bit count");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < divisor_i)
    else $error("remainder not below divisor");
`endif

endmodule

/* rtl/core/trial_division_primality_core.sv */
// channel  dir  handshake             payload
// s_axis   in   tvalid/tready         tdata: number
// m_axis   out  tvalid/tready         tdata: verdict, divisor_count, smallest_factor
//
// each trial divisor d = 2, 3, ... is run through the bit-serial divider;
// trials run while d <= n / d, about floor(sqrt(n)) of them.
// an item with n below four is settled without a trial; one item is worked at a time.
// the output register lets a new item enter while a result waits on m_axis.
// reset clears the control state only; no clearing pass is needed.
module trial_division_primality_core #(
  parameter int NUMBER_BITS = 31,
  localparam int InW  = ((NUMBER_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * NUMBER_BITS + 2 + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // number
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o    // verdict, divisor_count, smallest_factor
);

  import tdp_pkg::*;

  localparam int N = NUMBER_BITS;

  tdp_state_e state_q, state_d;

  logic [N-1:0] n_q, n_d;
  logic [N-1:0] d_q, d_d;
  logic [N-1:0] cnt_q, cnt_d;
  logic [N-1:0] small_q, small_d;
  verdict_e     verd_q, verd_d;

  logic         out_valid_q, out_valid_d;
  verdict_e     out_verd_q;
  logic [N-1:0] out_cnt_q, out_small_q;
  logic         out_load;

  logic         div_start, div_done;
  logic [N-1:0] div_quo, div_rem;
  logic [N-1:0] n_in;

  assign n_in = s_axis_tdata_i[N-1:0];

  // the first trial starts in the accept cycle, so the divider takes the next value
  tdp_serial_div #(
    .W(N)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_d),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    cnt_d     = cnt_q;
    small_d   = small_q;
    verd_d    = verd_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          n_d     = n_in;
          small_d = '0;
          if (n_in == '0) begin
            verd_d  = VERDICT_NO_TEST;
            cnt_d   = '0;
            state_d = ST_DONE;
          end else if (n_in == N'(1)) begin
            verd_d  = VERDICT_NOT_PRIME;
            cnt_d   = N'(1);
            state_d = ST_DONE;
          end else if (n_in < N'(SmallLimit)) begin
            verd_d  = VERDICT_PRIME;
            cnt_d   = N'(2);
            state_d = ST_DONE;
          end else begin
            d_d       = N'(2);
            cnt_d     = N'(2);
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_q > div_quo) begin
            verd_d  = (cnt_q > N'(2)) ? VERDICT_NOT_PRIME : VERDICT_PRIME;
            state_d = ST_DONE;
          end else begin
            if (div_rem == '0) begin
              if (small_q == '0) begin
                small_d = d_q;
              end
              // a square root divisor counts once
              cnt_d = cnt_q + ((d_q == div_quo) ? N'(1) : N'(2));
            end
            d_d       = d_q + N'(1);
            div_start = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    cnt_q   <= cnt_d;
    small_q <= small_d;
    verd_q  <= verd_d;
    if (out_load) begin
      out_verd_q  <= verd_q;
      out_cnt_q   <= cnt_q;
      out_small_q <= small_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'({out_small_q, out_cnt_q, out_verd_q});

`ifndef SYNTH
  a_prime_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_verd_q == VERDICT_PRIME) |->
      (out_small_q == '0 && out_cnt_q == N'(2)))
    else $error("prime result with divisor fields set");
  a_no_test_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_verd_q == VERDICT_NO_TEST) |->
      (out_small_q == '0 && out_cnt_q == '0))
    else $error("no-test result with divisor fields set");
  a_trial_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (n_q >= N'(SmallLimit) && d_q >= N'(2)))
    else $error("trial division on a small value or divisor");
`endif

endmodule
